// ===== design/i2c_bit_level_master_core_macros.svh =====
// assertion macros for the i2c bit level master core
// no dependencies, taken in by the top level
`ifndef I2C_BIT_LEVEL_MASTER_CORE_MACROS_SVH
`define I2C_BIT_LEVEL_MASTER_CORE_MACROS_SVH

// same-cycle implication
`define I2CM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define I2CM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/i2cm_pkg.sv =====
// shared types, codes and line-level helper for the i2c bit level master core
// no dependencies
package i2cm_pkg;

   localparam int unsigned HALF_PERIOD_RESET = 50;
   localparam int unsigned BITS_PER_BYTE     = 8;

   localparam logic [2:0] MODE_START = 3'd0;
   localparam logic [2:0] MODE_STOP  = 3'd1;
   localparam logic [2:0] MODE_SEND  = 3'd2;
   localparam logic [2:0] MODE_ACK   = 3'd3;
   localparam logic [2:0] MODE_READ  = 3'd4;

   typedef enum logic [6:0] {
      PH_IDLE   = 7'b0000001,
      PH_FIRST  = 7'b0000010,
      PH_SECOND = 7'b0000100,
      PH_THIRD  = 7'b0001000,
      PH_FOURTH = 7'b0010000,
      PH_FIFTH  = 7'b0100000,
      PH_SIXTH  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] mode;
      logic [7:0] data_byte;
      logic       send_ack;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_seen;
   } rsp_type;

   // bus levels of a phase, returned as {scl, sda}
   function automatic logic [1:0] phase_lines(input logic [2:0] mode,
                                              input phase_type phase,
                                              input logic msb,
                                              input logic ack_choice);
      logic [1:0] lines;
      logic       a;
      a = ~ack_choice;
      unique case (mode)
         MODE_START: begin
            if (phase == PH_FIRST)       lines = 2'b11;
            else if (phase == PH_SECOND) lines = 2'b10;
            else                         lines = 2'b00;
         end
         MODE_STOP: begin
            if (phase == PH_FIRST)       lines = 2'b00;
            else if (phase == PH_SECOND) lines = 2'b10;
            else                         lines = 2'b11;
         end
         MODE_SEND: lines = {phase == PH_SECOND, msb};
         MODE_ACK:  lines = {phase == PH_FIRST, 1'b1};
         default: begin
            if (phase == PH_FIRST)                          lines = 2'b11;
            else if (phase == PH_SECOND)                    lines = 2'b01;
            else if (phase == PH_THIRD || phase == PH_FIFTH) lines = {1'b0, a};
            else if (phase == PH_FOURTH)                    lines = {1'b1, a};
            else                                            lines = 2'b01;
         end
      endcase
      return lines;
   endfunction

endpackage

// ===== design/i2cm_in_reg.sv =====
// input register stage: takes request beats and holds one until the engine consumes it
// depends on i2cm_pkg
module i2cm_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,  // data_byte[7:0], send_ack[8], sda_in[9], zero[15:10]
   input  logic [3:0]        req_tuser,  // cmd_valid[0], mode[3:1]
   input  logic              advance,
   output logic              item_valid,
   output i2cm_pkg::req_type item
);

   logic              valid_ff, valid_in;
   i2cm_pkg::req_type item_ff, item_in;

   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         if (req_tvalid) begin
            item_in.cmd_valid = req_tuser[0];
            item_in.mode      = req_tuser[3:1];
            item_in.data_byte = req_tdata[7:0];
            item_in.send_ack  = req_tdata[8];
            item_in.sda_in    = req_tdata[9];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== design/i2cm_engine.sv =====
// bus phase engine: state registers and the per-tick update of the bit engine
// depends on i2cm_pkg
module i2cm_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data,
   input  logic              fire,
   input  i2cm_pkg::req_type item,
   output i2cm_pkg::rsp_type result
);

   logic [15:0]         half_ff, tc_ff, tc_in;
   i2cm_pkg::phase_type ph_ff, ph_in;
   logic [3:0]          bi_ff, bi_in;
   logic [7:0]          sh_ff, sh_in;
   logic [2:0]          am_ff, am_in;
   logic                ac_ff, ac_in;
   logic                scl_ff, scl_in;
   logic                sda_ff, sda_in;
   logic                busy_ff, busy_in;
   logic                ack_ff, ack_in;
   logic [7:0]          last_ff, last_in;

   always_comb begin
      logic [15:0] limit;
      logic [15:0] tc_next;
      logic [3:0]  bi_next;
      logic [1:0]  lines;
      logic        fin;
      tc_in     = tc_ff;
      ph_in     = ph_ff;
      bi_in     = bi_ff;
      sh_in     = sh_ff;
      am_in     = am_ff;
      ac_in     = ac_ff;
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      busy_in   = busy_ff;
      ack_in    = ack_ff;
      last_in   = last_ff;
      fin       = 1'b0;
      tc_next   = 16'd0;
      bi_next   = 4'd0;
      lines     = 2'b00;
      limit     = (half_ff == 16'd0) ? 16'd1 : half_ff;

      if (!busy_ff && item.cmd_valid && item.mode <= i2cm_pkg::MODE_READ) begin
         am_in   = item.mode;
         ac_in   = item.send_ack;
         sh_in   = (item.mode == i2cm_pkg::MODE_SEND) ? item.data_byte : 8'd0;
         bi_in   = 4'd0;
         tc_in   = 16'd0;
         ph_in   = i2cm_pkg::PH_FIRST;
         busy_in = 1'b1;
         lines   = i2cm_pkg::phase_lines(am_in, ph_in, sh_in[7], ac_in);
         scl_in  = lines[1];
         sda_in  = lines[0];
      end

      result.scl_level = scl_in;
      result.sda_level = sda_in;
      result.busy_res  = busy_in;

      if (busy_in) begin
         tc_next = tc_in + 16'd1;
         if (tc_next >= limit) begin
            tc_in   = 16'd0;
            bi_next = bi_in + 4'd1;
            unique case (am_in)
               i2cm_pkg::MODE_START, i2cm_pkg::MODE_STOP: begin
                  unique case (ph_in)
                     i2cm_pkg::PH_FIRST:  ph_in = i2cm_pkg::PH_SECOND;
                     i2cm_pkg::PH_SECOND: ph_in = i2cm_pkg::PH_THIRD;
                     default:             fin   = 1'b1;
                  endcase
               end
               i2cm_pkg::MODE_SEND: begin
                  if (ph_in == i2cm_pkg::PH_FIRST) begin
                     ph_in = i2cm_pkg::PH_SECOND;
                  end else begin
                     sh_in = {sh_in[6:0], 1'b0};
                     bi_in = bi_next;
                     if (bi_next >= 4'(i2cm_pkg::BITS_PER_BYTE)) begin
                        scl_in = 1'b0;
                        fin    = 1'b1;
                     end else begin
                        ph_in = i2cm_pkg::PH_FIRST;
                     end
                  end
               end
               i2cm_pkg::MODE_ACK: begin
                  if (ph_in == i2cm_pkg::PH_FIRST) begin
                     ack_in = item.sda_in;
                     ph_in  = i2cm_pkg::PH_SECOND;
                  end else begin
                     fin = 1'b1;
                  end
               end
               default: begin
                  priority if (ph_in == i2cm_pkg::PH_FIRST) begin
                     sh_in = {sh_in[6:0], item.sda_in};
                     bi_in = bi_next;
                     if (bi_next >= 4'(i2cm_pkg::BITS_PER_BYTE)) last_in = sh_in;
                     ph_in = i2cm_pkg::PH_SECOND;
                  end else if (ph_in == i2cm_pkg::PH_SECOND) begin
                     ph_in = (bi_in >= 4'(i2cm_pkg::BITS_PER_BYTE)) ?
                             i2cm_pkg::PH_THIRD : i2cm_pkg::PH_FIRST;
                  end else if (ph_in == i2cm_pkg::PH_THIRD) begin
                     ph_in = i2cm_pkg::PH_FOURTH;
                  end else if (ph_in == i2cm_pkg::PH_FOURTH) begin
                     ph_in = i2cm_pkg::PH_FIFTH;
                  end else if (ph_in == i2cm_pkg::PH_FIFTH && ac_in) begin
                     ph_in = i2cm_pkg::PH_SIXTH;
                  end else begin
                     fin = 1'b1;
                  end
               end
            endcase
            if (fin) begin
               busy_in = 1'b0;
               ph_in   = i2cm_pkg::PH_IDLE;
               bi_in   = 4'd0;
            end else begin
               lines  = i2cm_pkg::phase_lines(am_in, ph_in, sh_in[7], ac_in);
               scl_in = lines[1];
               sda_in = lines[0];
            end
         end else begin
            tc_in = tc_next;
         end
      end

      result.done_res  = fin;
      result.read_byte = last_in;
      result.ack_seen  = ack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= 16'(i2cm_pkg::HALF_PERIOD_RESET);
      end else if (csr_wr_en) begin
         half_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff   <= 16'd0;
         ph_ff   <= i2cm_pkg::PH_IDLE;
         bi_ff   <= 4'd0;
         sh_ff   <= 8'd0;
         am_ff   <= i2cm_pkg::MODE_START;
         ac_ff   <= 1'b0;
         scl_ff  <= 1'b1;
         sda_ff  <= 1'b1;
         busy_ff <= 1'b0;
         ack_ff  <= 1'b1;
         last_ff <= 8'd0;
      end else if (fire) begin
         tc_ff   <= tc_in;
         ph_ff   <= ph_in;
         bi_ff   <= bi_in;
         sh_ff   <= sh_in;
         am_ff   <= am_in;
         ac_ff   <= ac_in;
         scl_ff  <= scl_in;
         sda_ff  <= sda_in;
         busy_ff <= busy_in;
         ack_ff  <= ack_in;
         last_ff <= last_in;
      end
   end

endmodule

// ===== design/i2cm_out_reg.sv =====
// result register stage: holds one result beat until the consumer takes it
// depends on i2cm_pkg
module i2cm_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  i2cm_pkg::rsp_type result,
   output logic              advance,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,  // scl[0], sda[1], busy[2], read_byte[10:3],
                                         // ack_seen[11], zero[15:12]
   output logic              rsp_tlast   // done
);

   logic              valid_ff;
   i2cm_pkg::rsp_type res_ff;

   assign advance = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= fire;
      end
      if (advance && fire) begin
         res_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0000, res_ff.ack_seen, res_ff.read_byte,
                        res_ff.busy_res, res_ff.sda_level, res_ff.scl_level};
   assign rsp_tlast  = res_ff.done_res;

endmodule

// ===== design/i2c_bit_level_master_core.sv =====
// i2c bit level master core: one beat in per bus tick, one result beat out per tick
// path: a request beat is registered in the input register stage, its result beat in the result register stage
// throughput: one beat per cycle while the result consumer does not hold rsp_tready low
// reset: synchronous active high; bus released, idle, half period back to 50 ticks
// depends on i2cm_pkg, i2cm_in_reg, i2cm_engine, i2cm_out_reg and the macro header
`include "i2c_bit_level_master_core_macros.svh"
module i2c_bit_level_master_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,  // half_period_ticks[15:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // data_byte[7:0], send_ack[8], sda_in[9], zero[15:10]
   input  logic [3:0]  req_tuser,    // cmd_valid[0], mode[3:1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // scl[0], sda[1], busy[2], read_byte[10:3],
                                     // ack_seen[11], zero[15:12]
   output logic        rsp_tlast     // done
);

   logic              advance;
   logic              item_valid;
   logic              fire;
   i2cm_pkg::req_type item;
   i2cm_pkg::rsp_type result;

   assign fire = item_valid && advance;

   i2cm_in_reg u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   i2cm_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .item        (item),
      .result      (result)
   );

   i2cm_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .result     (result),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `I2CM_ASSERT_NOW(a_done_busy, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[2], "done no busy")
   `I2CM_ASSERT_NEXT(a_fire_out, clock, reset, fire, rsp_tvalid, "engine beat lost")
   `I2CM_ASSERT_NEXT(a_hold_in, clock, reset, item_valid && !advance, item_valid, "input dropped")

endmodule
